// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/nwps_pkg.sv =====
// Types and constants shared by the nibble wildcard pattern scanner.
package nwps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int POSITION_BITS     = 32;
	localparam int ADDR_BITS         = 48;
	localparam int OFFSET_BITS       = 32;
	localparam int LEN_BITS          = 5;
	localparam int OCC_BITS          = 8;
	localparam int CFG_DATA_BITS     = 64;
	localparam int CFG_INDEX_BITS    = 3;
	localparam int HIST_DEPTH        = MAX_PATTERN_BYTES - 1;
	localparam int IDX_BITS          = $clog2(MAX_PATTERN_BYTES);
	localparam int FILL_BITS         = $clog2(MAX_PATTERN_BYTES);

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW   = 3'd0,
		REG_PATTERN_HIGH  = 3'd1,
		REG_COMPARE_MASK  = 3'd2,
		REG_PATTERN_LEN   = 3'd3,
		REG_OCCURRENCE    = 3'd4,
		REG_BASE_ADDRESS  = 3'd5,
		REG_RESULT_OFFSET = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [8*MAX_PATTERN_BYTES-1:0] pattern;
		logic [2*MAX_PATTERN_BYTES-1:0] cmp_mask;
		logic [LEN_BITS-1:0]            length;
	} pattern_cfg_t;

endpackage

// ===== hdl/nwps_in_if.sv =====
// Input channel: one buffer byte per item.
interface nwps_in_if;
	import nwps_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/nwps_out_if.sv =====
// Result channel: found flag and match address.
interface nwps_out_if;
	import nwps_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [ADDR_BITS-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

// ===== hdl/nibble_wildcard_pattern_scanner.sv =====
// An item is registered at acceptance and its result is offered from the result register once it advances.
// Throughput: one byte per cycle unless a result waits on a stalled output; the window compare
// against all pattern bytes is one combinational pass between the input and result registers.
// A result waiting at the output does not block the next byte unless that byte also has one.
// Reset clears configuration, scan state and both pipeline valids; no clearing pass is needed.
`include "assert_macros.svh"

module nibble_wildcard_pattern_scanner
	import nwps_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	nwps_in_if.sink                   in_ch,
	nwps_out_if.source                out_ch
);

	// Configuration registers.
	logic [63:0]                  pat_low_q;
	logic [63:0]                  pat_high_q;
	logic [2*MAX_PATTERN_BYTES-1:0] mask_q;
	logic [LEN_BITS-1:0]          len_q;
	logic [OCC_BITS-1:0]          occ_q;
	logic [ADDR_BITS-1:0]         base_q;
	logic [OFFSET_BITS-1:0]       offset_q;

	// Input stage.
	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;

	// Scan state.
	byte_t                   hist_q [HIST_DEPTH];
	logic [FILL_BITS-1:0]    fill_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [OCC_BITS-1:0]     matches_q;
	logic                    reported_q;

	// Result stage.
	logic                     out_valid_q;
	logic                     out_found_q;
	logic [POSITION_BITS-1:0] out_start_q;

	pattern_cfg_t             pcfg;
	logic [LEN_BITS-1:0]      avail;
	logic                     hit;
	logic                     sel;
	logic                     skip;
	logic                     res_valid;
	logic                     out_free;
	logic                     adv;
	logic [POSITION_BITS-1:0] start;
	logic [ADDR_BITS-1:0]     addr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			mask_q     <= '0;
			len_q      <= '0;
			occ_q      <= '0;
			base_q     <= '0;
			offset_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:   pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH:  pat_high_q <= cfg_data;
				REG_COMPARE_MASK:  mask_q     <= cfg_data[2*MAX_PATTERN_BYTES-1:0];
				REG_PATTERN_LEN:   len_q      <= cfg_data[LEN_BITS-1:0];
				REG_OCCURRENCE:    occ_q      <= cfg_data[OCC_BITS-1:0];
				REG_BASE_ADDRESS:  base_q     <= cfg_data[ADDR_BITS-1:0];
				REG_RESULT_OFFSET: offset_q   <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign pcfg.pattern  = {pat_high_q, pat_low_q};
	assign pcfg.cmp_mask = mask_q;
	assign pcfg.length   = len_q;

	// The fill count saturates one short of the window; the current byte adds one.
	assign avail = LEN_BITS'(fill_q) + LEN_BITS'(1);

	nwps_match u_match (
		.cfg   (pcfg),
		.cur   (data_s1),
		.hist  (hist_q),
		.avail (avail),
		.hit   (hit)
	);

	assign sel       = hit && !reported_q && (matches_q == occ_q);
	assign skip      = hit && !reported_q && (matches_q != occ_q);
	assign res_valid = valid_s1 && (sel || (last_s1 && !reported_q));
	assign start     = pos_q + POSITION_BITS'(1) - POSITION_BITS'(len_q);

	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv         = valid_s1 && (!res_valid || out_free);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// History bytes beyond the fill count are never compared, so they need no clearing.
	always_ff @(posedge clk) begin
		if (adv) begin
			hist_q[0] <= data_s1;
			for (int k = 1; k < HIST_DEPTH; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			pos_q      <= '0;
			matches_q  <= '0;
			reported_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				fill_q     <= '0;
				pos_q      <= '0;
				matches_q  <= '0;
				reported_q <= 1'b0;
			end else begin
				if (fill_q != '1) begin
					fill_q <= fill_q + FILL_BITS'(1);
				end
				pos_q <= pos_q + POSITION_BITS'(1);
				if (skip) begin
					matches_q <= matches_q + OCC_BITS'(1);
				end
				if (sel) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_found_q <= sel;
			out_start_q <= start;
		end
	end

	// The user must change configuration only while no result is pending (unenforced); the add follows the register.
	assign addr_sum = base_q + ADDR_BITS'(out_start_q) + ADDR_BITS'(offset_q);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.found         = out_found_q;
	assign out_ch.match_address = out_found_q ? addr_sum : '0;

	`ASSERT_IMPL(a_notfound_zero, clk, arst_n, out_ch.valid && !out_ch.found, out_ch.match_address == '0, "not-found item carries a nonzero address")
	`ASSERT_NEXT(a_last_clears, clk, arst_n, adv && last_s1, (pos_q == '0) && (matches_q == '0) && !reported_q && (fill_q == '0), "scan state not cleared after the last byte")
	`ASSERT_NEXT(a_pos_steps, clk, arst_n, adv && !last_s1, pos_q == $past(pos_q) + POSITION_BITS'(1), "byte position did not advance by one")
	`ASSERT_IMPL(a_no_result_after_report, clk, arst_n, valid_s1 && reported_q, !res_valid, "result produced after the selected match was reported")

endmodule

// ===== hdl/nwps_match.sv =====
// Masked nibble compare of the byte window against the pattern.
module nwps_match
	import nwps_pkg::*;
(
	input  pattern_cfg_t        cfg,
	input  byte_t               cur,
	input  byte_t               hist [HIST_DEPTH],
	input  logic [LEN_BITS-1:0] avail,
	output logic                hit
);

	byte_t               win [MAX_PATTERN_BYTES];
	logic                all_ok;
	logic                len_ok;
	logic [LEN_BITS-1:0] back;
	logic [IDX_BITS-1:0] idx;
	byte_t               d;
	byte_t               p;

	always_comb begin
		win[0] = cur;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win[k] = hist[k-1];
		end
	end

	// Pattern byte i lines up with the byte that came len-1-i items ago.
	always_comb begin
		all_ok = 1'b1;
		back   = '0;
		idx    = '0;
		d      = '0;
		p      = '0;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			if (LEN_BITS'(i) < cfg.length) begin
				back = cfg.length - LEN_BITS'(1) - LEN_BITS'(i);
				idx  = back[IDX_BITS-1:0];
				d    = win[idx];
				p    = cfg.pattern[8*i +: 8];
				if (cfg.cmp_mask[2*i] && (d[7:4] != p[7:4])) begin
					all_ok = 1'b0;
				end
				if (cfg.cmp_mask[2*i+1] && (d[3:0] != p[3:0])) begin
					all_ok = 1'b0;
				end
			end
		end
	end

	assign len_ok = (cfg.length != '0)
		&& (cfg.length <= LEN_BITS'(MAX_PATTERN_BYTES))
		&& (avail >= cfg.length);
	assign hit = len_ok && all_ok;

endmodule
